// ===== rtl/circular_queue_with_dump_macros.svh =====
// Assertion macros shared by the circular queue RTL.
`ifndef CIRCULAR_QUEUE_WITH_DUMP_MACROS_SVH
`define CIRCULAR_QUEUE_WITH_DUMP_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CQD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Delayed implication: the consequent is checked after the antecedent.
`define CQD_ASSERT_LATER2(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##2 (cons)) \
    else $error(msg);

`endif

// ===== rtl/cqd_pkg.sv =====
// Shared constants and controller/datapath interface types for the circular queue.
`default_nettype none

package cqd_pkg;

  localparam int DEPTH_DEF = 8;
  localparam int WORD_W    = 32;
  localparam int ACT_W     = 2;
  localparam int STAT_W    = 2;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_TRAV   = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd3;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;  // capture the accepted transaction
    logic exec;   // carry out one step of the held action
    logic load;   // move the step's result into the output register
  } cqd_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic noop;      // held action code has no meaning
    logic res_last;  // the pending result is the final one for this transaction
  } cqd_sts_t;

endpackage

`default_nettype wire

// ===== rtl/cqd_ctrl.sv =====
// Controller state machine of the circular queue: sequencing and output valid.
`default_nettype none

module cqd_ctrl
  import cqd_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  wire logic     out_ready,
  input  wire cqd_sts_t sts,
  output cqd_cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_EXEC = 3'b010,
    S_LOAD = 3'b100
  } state_t;

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   slot_free;

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  always_comb begin
    state_next     = state;
    cmd            = '0;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = sts.noop ? S_IDLE : S_LOAD;
      end
      S_LOAD: begin
        if (slot_free) begin
          cmd.load       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = sts.res_last ? S_IDLE : S_EXEC;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/cqd_dp.sv =====
// Datapath of the circular queue: slot memory, pointers, step logic and output register.
`default_nettype none

module cqd_dp
  import cqd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire cqd_cmd_t                 cmd,
  output cqd_sts_t                      sts,
  output logic [$clog2(DEPTH+1)-1:0]    fill_count,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic signed [WORD_W-1:0] value,
  output logic [STAT_W-1:0]             status,
  output logic signed [WORD_W-1:0]      data,
  output logic                          last
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(DEPTH);
  localparam logic [CNT_W-1:0] FULL_C  = CNT_W'(DEPTH);

  logic signed [WORD_W-1:0] slots [DEPTH];
  logic signed [WORD_W-1:0] rd_data;

  logic [ACT_W-1:0]         act_q;
  logic signed [WORD_W-1:0] value_q;
  logic [IDX_W-1:0]         head;
  logic [IDX_W-1:0]         head_next;
  logic [CNT_W-1:0]         fill_count_next;
  logic [IDX_W-1:0]         idx;
  logic [IDX_W-1:0]         idx_next;

  logic [STAT_W-1:0] res_status;
  logic [STAT_W-1:0] res_status_next;
  logic              res_last;
  logic              res_last_next;
  logic              res_use_rd;
  logic              res_use_rd_next;

  logic             wr_en;
  logic             rd_en;
  logic [IDX_W-1:0] tail_addr;
  logic [IDX_W-1:0] trav_addr;
  logic [IDX_W-1:0] head_inc;
  logic [IDX_W-1:0] rd_addr;
  logic             is_full;
  logic             is_empty;
  logic             trav_end;

  // Add two in-range offsets and wrap once round the ring.
  function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] base,
                                                input logic [CNT_W-1:0] off);
    logic [CNT_W:0] sum;
    sum = (CNT_W + 1)'(base) + (CNT_W + 1)'(off);
    if (sum >= DEPTH_S) begin
      sum = sum - DEPTH_S;
    end
    return sum[IDX_W-1:0];
  endfunction

  assign is_full   = (fill_count == FULL_C);
  assign is_empty  = (fill_count == '0);
  assign tail_addr = wrap_add(head, fill_count);
  assign trav_addr = wrap_add(head, CNT_W'(idx));
  assign head_inc  = wrap_add(head, CNT_W'(1));
  assign trav_end  = ((CNT_W'(idx) + CNT_W'(1)) == fill_count);

  assign sts.noop     = !(act_q == ACT_INSERT || act_q == ACT_DELETE || act_q == ACT_TRAV);
  assign sts.res_last = res_last;

  always_comb begin
    head_next       = head;
    fill_count_next = fill_count;
    idx_next        = idx;
    res_status_next = res_status;
    res_last_next   = res_last;
    res_use_rd_next = res_use_rd;
    wr_en           = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head;
    if (cmd.latch) begin
      idx_next = '0;
    end else if (cmd.exec) begin
      res_status_next = ST_OK;
      res_last_next   = 1'b1;
      res_use_rd_next = 1'b0;
      unique case (act_q)
        ACT_INSERT: begin
          if (is_full) begin
            res_status_next = ST_OVERFLOW;
          end else begin
            wr_en           = 1'b1;
            fill_count_next = fill_count + CNT_W'(1);
          end
        end
        ACT_DELETE: begin
          if (is_empty) begin
            res_status_next = ST_UNDERFLOW;
          end else begin
            rd_en           = 1'b1;
            res_use_rd_next = 1'b1;
            head_next       = head_inc;
            fill_count_next = fill_count - CNT_W'(1);
          end
        end
        ACT_TRAV: begin
          if (is_empty) begin
            res_status_next = ST_EMPTY;
          end else begin
            rd_en           = 1'b1;
            rd_addr         = trav_addr;
            res_use_rd_next = 1'b1;
            res_last_next   = trav_end;
            idx_next        = trav_end ? '0 : idx + IDX_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Single-port slot memory with registered read data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      slots[tail_addr] <= value_q;
    end
    if (rd_en) begin
      rd_data <= slots[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head       <= '0;
      fill_count <= '0;
      idx        <= '0;
      res_last   <= 1'b1;
    end else begin
      head       <= head_next;
      fill_count <= fill_count_next;
      idx        <= idx_next;
      res_last   <= res_last_next;
    end
  end

  always_ff @(posedge clk) begin
    res_status <= res_status_next;
    res_use_rd <= res_use_rd_next;
    if (cmd.latch) begin
      act_q   <= action;
      value_q <= value;
    end
    if (cmd.load) begin
      status <= res_status;
      data   <= res_use_rd ? rd_data : '0;
      last   <= res_last;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/circular_queue_with_dump.sv =====
// A transaction is accepted only in S_IDLE, after the last one; it runs in S_EXEC and its result
// goes to the output register in S_LOAD once that register is free. Insert and delete make one
// such pass; a traverse makes one per stored word, each word through one registered read of the
// single-port memory. An undefined action code returns from S_EXEC to S_IDLE with no result.
// Reset (rst, synchronous, active high) empties the queue and clears head and valid flags.
`default_nettype none

module circular_queue_with_dump
  import cqd_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic [ACT_W-1:0]         action,
  input  wire logic signed [WORD_W-1:0] value,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic [STAT_W-1:0]             status,
  output logic signed [WORD_W-1:0]      data,
  output logic                          last
);

  `include "circular_queue_with_dump_macros.svh"

  localparam int CNT_W = $clog2(DEPTH + 1);

  // The controller only steps the datapath; all queue state lives in the datapath.
  cqd_cmd_t         cmd;
  cqd_sts_t         sts;
  logic [CNT_W-1:0] fill_count;

  // Each input transaction is captured, executed one step at a time (one step per
  // traversed word) and every step's result is moved into the output register once
  // that register is free. While a result is still held there, the next step and the
  // next input transaction may proceed, but the next result waits in S_LOAD for the receiver to take it.
  cqd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cqd_dp #(
    .DEPTH (DEPTH)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .fill_count (fill_count),
    .action     (action),
    .value      (value),
    .status     (status),
    .data       (data),
    .last       (last)
  );

  // The fill count can never pass the queue depth.
  `CQD_ASSERT_NOW(a_count_bound, 1'b1, fill_count <= CNT_W'(DEPTH), "fill count above depth")

  // An insert into a queue with room grows it by exactly one word.
  `CQD_ASSERT_LATER2(a_insert_grows,
    in_valid && in_ready && action == ACT_INSERT && fill_count != CNT_W'(DEPTH),
    fill_count == $past(fill_count, 2) + CNT_W'(1), "insert did not add one word")

  // A delete on an empty queue leaves it empty.
  `CQD_ASSERT_LATER2(a_underflow_keeps,
    in_valid && in_ready && action == ACT_DELETE && fill_count == '0,
    fill_count == '0, "underflowing delete changed the fill count")

endmodule

`default_nettype wire
